/* rtl/core/fsot_pkg.sv */
// Shared types and codes for the frame slot ownership tracker.
package fsot_pkg;

   localparam int MODE_W   = 3;
   localparam int IDX_W    = 4;
   localparam int FLAG_W   = 4;
   localparam int STATUS_W = 2;

   // command modes
   localparam logic [MODE_W-1:0] MODE_CLAIM    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ABORT    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PROMOTE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REL_DISP = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RETAIN   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_REL_TX   = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   // ownership flag bits
   localparam int BIT_STAGING = 0;
   localparam int BIT_LATEST  = 1;
   localparam int BIT_DISPLAY = 2;
   localparam int BIT_TX      = 3;

   localparam logic [FLAG_W-1:0] FL_NONE    = 4'b0000;
   localparam logic [FLAG_W-1:0] FL_STAGING = 4'b0001;
   localparam logic [FLAG_W-1:0] FL_LATEST  = 4'b0010;
   localparam logic [FLAG_W-1:0] FL_DISPLAY = 4'b0100;
   localparam logic [FLAG_W-1:0] FL_TX      = 4'b1000;

   // registered request, seen by every cell
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              header_valid;
   } cmd_type;

   // row-wide control fed back into the cells
   typedef struct packed {
      logic exec;
      logic any_staging;
      logic any_display;
      logic promote_go;
   } ctl_type;

   // per-cell status towards the top
   typedef struct packed {
      logic staging;
      logic display;
      logic addr_ok;
      logic take;
   } cell_stat_type;

endpackage

/* rtl/core/fsot_cell.sv */
// One slot of the ownership row: its flags and the claim/latest priority links.
module fsot_cell import fsot_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  ctl_type       ctl,
   input  logic          hit,
   input  logic          claim_in,
   input  logic          latest_in,
   output logic          claim_out,
   output logic          latest_out,
   output cell_stat_type stat
);

   logic [FLAG_W-1:0] flags_ff;
   logic [FLAG_W-1:0] flags_in;
   logic              empty;
   logic              take_empty;
   logic              take_latest;
   logic              addr_ok;

   assign empty       = (flags_ff == FL_NONE);
   assign take_empty  = empty & ~claim_in;
   assign claim_out   = claim_in | empty;
   assign take_latest = flags_ff[BIT_LATEST] & ~latest_in;
   assign latest_out  = latest_in | flags_ff[BIT_LATEST];

   always_comb begin
      case (cmd.mode)
         MODE_ABORT:    addr_ok = hit && (flags_ff == FL_STAGING);
         MODE_PROMOTE:  addr_ok = hit && (flags_ff == FL_STAGING) && cmd.header_valid;
         MODE_REL_DISP: addr_ok = hit && flags_ff[BIT_DISPLAY];
         MODE_RETAIN:   addr_ok = hit && !empty && !flags_ff[BIT_STAGING] && !flags_ff[BIT_TX];
         MODE_REL_TX:   addr_ok = hit && flags_ff[BIT_TX];
         default:       addr_ok = 1'b0;
      endcase
   end

   always_comb begin
      flags_in = flags_ff;
      case (cmd.mode)
         MODE_CLAIM: begin
            if (!ctl.any_staging && take_empty) flags_in = FL_STAGING;
         end
         MODE_ABORT: begin
            if (addr_ok) flags_in = FL_NONE;
         end
         MODE_PROMOTE: begin
            // latest moves to the promoted slot, every other slot loses it
            if (ctl.promote_go) flags_in = hit ? FL_LATEST : (flags_ff & ~FL_LATEST);
         end
         MODE_ACQUIRE: begin
            if (!ctl.any_display && take_latest) flags_in = flags_ff | FL_DISPLAY;
         end
         MODE_REL_DISP: begin
            if (addr_ok) flags_in = flags_ff & ~FL_DISPLAY;
         end
         MODE_RETAIN: begin
            if (addr_ok) flags_in = flags_ff | FL_TX;
         end
         MODE_REL_TX: begin
            if (addr_ok) flags_in = flags_ff & ~FL_TX;
         end
         default: flags_in = flags_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FL_NONE;
      end else if (ctl.exec) begin
         flags_ff <= flags_in;
      end
   end

   assign stat.staging = flags_ff[BIT_STAGING];
   assign stat.display = flags_ff[BIT_DISPLAY];
   assign stat.addr_ok = addr_ok;
   assign stat.take    = ((cmd.mode == MODE_CLAIM) && take_empty) ||
                         ((cmd.mode == MODE_ACQUIRE) && take_latest);

endmodule

/* rtl/core/frame_slot_ownership_tracker_unit.sv */
// Top level of the frame slot ownership tracker: request register, cell row, response register.
// Tracks SLOTS frame-buffer slots, each with staging, latest, display and transmit
// ownership flags, all clear after reset. A request (mode and header_valid in tuser,
// slot index in tdata) is registered first and then executed across the row of slot
// cells, where the lowest free or latest slot is found by a priority link rippling
// from cell to cell; the response (status in tuser, granted slot in tdata) then sits
// in an output register. A new request is accepted only once the previous one has
// executed, also while its response still waits; execution holds while the response
// register is full and rsp_tready is low.
module frame_slot_ownership_tracker_unit import fsot_pkg::*; #(
   parameter int SLOTS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [3:0] slot_index, [7:4] zero
   input  logic [3:0] req_tuser,  // [2:0] mode, [3] header_valid
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [3:0] granted_slot, [7:4] zero
   output logic [1:0] rsp_tuser   // [1:0] status
);

   logic              cmd_valid_ff;
   cmd_type           cmd_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [IDX_W-1:0]  granted_ff;
   logic [IDX_W-1:0]  granted_in;

   ctl_type           ctl;
   cell_stat_type     stat [SLOTS];
   logic [SLOTS:0]    claim_chain;
   logic [SLOTS:0]    latest_chain;
   logic [SLOTS-1:0]  staging_vec;
   logic [SLOTS-1:0]  display_vec;
   logic [SLOTS-1:0]  ok_vec;
   logic              any_ok;
   logic              req_fire;

   assign req_tready = !cmd_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign ctl.exec   = cmd_valid_ff && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_fire) begin
         cmd_valid_ff <= 1'b1;
      end else if (ctl.exec) begin
         cmd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff.mode         <= req_tuser[2:0];
         cmd_ff.header_valid <= req_tuser[3];
         idx_ff              <= req_tdata[3:0];
      end
   end

   assign claim_chain[0]  = 1'b0;
   assign latest_chain[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      fsot_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd_ff),
         .ctl        (ctl),
         .hit        (idx_ff == IDX_W'(i)),
         .claim_in   (claim_chain[i]),
         .latest_in  (latest_chain[i]),
         .claim_out  (claim_chain[i+1]),
         .latest_out (latest_chain[i+1]),
         .stat       (stat[i])
      );
      assign staging_vec[i] = stat[i].staging;
      assign display_vec[i] = stat[i].display;
      assign ok_vec[i]      = stat[i].addr_ok;
   end

   assign ctl.any_staging = |staging_vec;
   assign ctl.any_display = |display_vec;
   assign any_ok          = |ok_vec;
   assign ctl.promote_go  = any_ok && (cmd_ff.mode == MODE_PROMOTE);

   always_comb begin
      case (cmd_ff.mode)
         MODE_CLAIM:
            status_in = (!ctl.any_staging && claim_chain[SLOTS]) ? ST_OK : ST_BUSY;
         MODE_ACQUIRE:
            status_in = ctl.any_display ? ST_BUSY :
                        (latest_chain[SLOTS] ? ST_OK : ST_NOTFOUND);
         MODE_ABORT, MODE_PROMOTE, MODE_REL_DISP, MODE_RETAIN, MODE_REL_TX:
            status_in = any_ok ? ST_OK : ST_INVALID;
         default:
            status_in = ST_INVALID;
      endcase
   end

   // at most one cell takes; granted is zero unless the request succeeded
   always_comb begin
      granted_in = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (stat[i].take && (status_in == ST_OK)) granted_in = granted_in | IDX_W'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         status_ff  <= status_in;
         granted_ff <= granted_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, granted_ff};
   assign rsp_tuser  = status_ff;

endmodule
